### rtl/core/msrs_pkg.sv
// ----------------------------------------------------------------------------
// msrs_pkg: shared definitions for the sorted mass range search
// Field widths, default parameter values, function codes, the sequencer state
// type and the result bundle that passes from the search engine to the top.
// ----------------------------------------------------------------------------
package msrs_pkg;

	// Fixed field widths of the external interface.
	localparam int IDX_W = 12;
	localparam int CNT_W = 13;

	// Default parameter values for the top level.
	localparam int DEF_TABLE_DEPTH = 4096;
	localparam int DEF_MASS_BITS   = 40;

	// Function codes carried by the func field.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Search sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_S1_RD,
		ST_S1_CMP,
		ST_CK_LO,
		ST_CK_HI,
		ST_S2_RD,
		ST_S2_CMP,
		ST_FINISH
	} state_t;

	// One query answer as handed from the engine to the output register.
	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] first;
		logic [IDX_W-1:0] last;
	} res_t;

endpackage

### rtl/core/msrs_engine.sv
// ----------------------------------------------------------------------------
// msrs_engine: mass table and binary search sequencer
// Holds the mass table in a memory with a write port and a registered read port,
// and runs both binary searches and the bound check through one mass comparator.
// ----------------------------------------------------------------------------
module msrs_engine #(
	parameter int TABLE_DEPTH = msrs_pkg::DEF_TABLE_DEPTH,
	parameter int MASS_BITS   = msrs_pkg::DEF_MASS_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic                       func,
	input  logic [msrs_pkg::IDX_W-1:0] entry_index,
	input  logic [MASS_BITS-1:0]       entry_mass,
	input  logic [MASS_BITS-1:0]       lower_bound,
	input  logic [MASS_BITS-1:0]       upper_bound,
	input  logic [msrs_pkg::CNT_W-1:0] entry_count,
	input  logic                       res_ready,
	output logic                       busy,
	output logic                       res_valid,
	output msrs_pkg::res_t             res
);

	// Address width of the table and width of a search position (0..depth).
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int PW = $clog2(TABLE_DEPTH + 1);
	localparam int WW = (PW > msrs_pkg::CNT_W) ? PW : msrs_pkg::CNT_W;

	msrs_pkg::state_t state_q, state_d;

	logic [PW-1:0]        lo_q, lo_d;
	logic [PW-1:0]        hi_q, hi_d;
	logic [PW-1:0]        mid_q, mid_d;
	logic [PW-1:0]        n_q, n_d;
	logic [PW-1:0]        first_q, first_d;
	logic [PW-1:0]        last_q, last_d;
	logic                 found_q, found_d;
	logic [MASS_BITS-1:0] lb_q, lb_d;
	logic [MASS_BITS-1:0] ub_q, ub_d;

	logic [MASS_BITS-1:0] mem [TABLE_DEPTH];
	logic [MASS_BITS-1:0] rdata_q;
	logic                 rd_en;
	logic [AW-1:0]        rd_addr;
	logic                 wr_en;

	logic [WW-1:0]        idx_ext;
	logic [WW-1:0]        cnt_ext;
	logic [WW-1:0]        n_ext;
	logic [PW-1:0]        n_lim;
	logic                 idx_ok;
	logic [PW-1:0]        mid;

	logic [MASS_BITS-1:0] cmp_a;
	logic [MASS_BITS-1:0] cmp_b;
	logic                 cmp_lt;

	logic [WW-1:0]        first_ext;
	logic [WW-1:0]        last_ext;

	// Clamp the configured count to the table depth and range-check loads.
	assign idx_ext = WW'(entry_index);
	assign cnt_ext = WW'(entry_count);
	assign n_ext   = (cnt_ext > WW'(TABLE_DEPTH)) ? WW'(TABLE_DEPTH) : cnt_ext;
	assign n_lim   = n_ext[PW-1:0];
	assign idx_ok  = idx_ext < WW'(TABLE_DEPTH);

	// Midpoint of the current search interval.
	assign mid = lo_q + ((hi_q - lo_q) >> 1);

	// Operand selection for the one shared mass comparator.
	always_comb begin
		case (state_q)
			msrs_pkg::ST_CK_HI,
			msrs_pkg::ST_S2_CMP: begin
				cmp_a = ub_q;
				cmp_b = rdata_q;
			end
			default: begin
				cmp_a = rdata_q;
				cmp_b = lb_q;
			end
		endcase
	end

	assign cmp_lt = cmp_a < cmp_b;

	// Table memory: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_ext[AW-1:0]] <= entry_mass;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Search datapath registers.
	always_ff @(posedge clk) begin
		lo_q    <= lo_d;
		hi_q    <= hi_d;
		mid_q   <= mid_d;
		n_q     <= n_d;
		first_q <= first_d;
		last_q  <= last_d;
		found_q <= found_d;
		lb_q    <= lb_d;
		ub_q    <= ub_d;
	end

	// Next state and datapath control.
	always_comb begin
		state_d   = state_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		mid_d     = mid_q;
		n_d       = n_q;
		first_d   = first_q;
		last_d    = last_q;
		found_d   = found_q;
		lb_d      = lb_q;
		ub_d      = ub_q;
		rd_en     = 1'b0;
		rd_addr   = mid[AW-1:0];
		wr_en     = 1'b0;
		res_valid = 1'b0;

		case (state_q)
			msrs_pkg::ST_IDLE: begin
				if (start) begin
					if (func == msrs_pkg::FUNC_LOAD) begin
						wr_en = idx_ok;
					end else begin
						lb_d    = lower_bound;
						ub_d    = upper_bound;
						n_d     = n_lim;
						lo_d    = '0;
						hi_d    = n_lim;
						found_d = 1'b0;
						state_d = (n_lim == '0) ? msrs_pkg::ST_FINISH : msrs_pkg::ST_S1_RD;
					end
				end
			end

			// First search: lowest position whose mass is at least the lower bound.
			msrs_pkg::ST_S1_RD: begin
				if (lo_q < hi_q) begin
					rd_en   = 1'b1;
					mid_d   = mid;
					state_d = msrs_pkg::ST_S1_CMP;
				end else begin
					first_d = lo_q;
					if (lo_q == n_q) begin
						state_d = msrs_pkg::ST_FINISH;
					end else begin
						rd_en   = 1'b1;
						rd_addr = lo_q[AW-1:0];
						state_d = msrs_pkg::ST_CK_LO;
					end
				end
			end

			msrs_pkg::ST_S1_CMP: begin
				if (cmp_lt) begin
					lo_d = mid_q + PW'(1);
				end else begin
					hi_d = mid_q;
				end
				state_d = msrs_pkg::ST_S1_RD;
			end

			// Check that the entry at the first position lies within both bounds.
			msrs_pkg::ST_CK_LO: begin
				state_d = cmp_lt ? msrs_pkg::ST_FINISH : msrs_pkg::ST_CK_HI;
			end

			msrs_pkg::ST_CK_HI: begin
				if (cmp_lt) begin
					state_d = msrs_pkg::ST_FINISH;
				end else begin
					lo_d    = '0;
					hi_d    = n_q;
					state_d = msrs_pkg::ST_S2_RD;
				end
			end

			// Second search: count of leading entries at most the upper bound.
			msrs_pkg::ST_S2_RD: begin
				if (lo_q < hi_q) begin
					rd_en   = 1'b1;
					mid_d   = mid;
					state_d = msrs_pkg::ST_S2_CMP;
				end else begin
					if (lo_q > first_q) begin
						found_d = 1'b1;
						last_d  = lo_q - PW'(1);
					end
					state_d = msrs_pkg::ST_FINISH;
				end
			end

			msrs_pkg::ST_S2_CMP: begin
				if (cmp_lt) begin
					hi_d = mid_q;
				end else begin
					lo_d = mid_q + PW'(1);
				end
				state_d = msrs_pkg::ST_S2_RD;
			end

			// Hold the answer until the output register can take it.
			msrs_pkg::ST_FINISH: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = msrs_pkg::ST_IDLE;
				end
			end

			default: begin
				state_d = msrs_pkg::ST_IDLE;
			end
		endcase
	end

	// Result bundle; indices read as zero when nothing was found.
	assign first_ext = WW'(first_q);
	assign last_ext  = WW'(last_q);
	assign res.found = found_q;
	assign res.first = found_q ? first_ext[msrs_pkg::IDX_W-1:0] : '0;
	assign res.last  = found_q ? last_ext[msrs_pkg::IDX_W-1:0] : '0;

	assign busy = (state_q != msrs_pkg::ST_IDLE);

endmodule

### rtl/core/sorted_mass_range_search.sv
// ----------------------------------------------------------------------------
// sorted_mass_range_search: range lookup over a sorted precursor mass table
// Top level with the count register, the input handshake and the result
// register in front of the search engine.
// ----------------------------------------------------------------------------
// A load transfer (func 0) writes one table entry in the cycle it is taken and
// leaves the block ready again at once; loads with an index at or beyond the
// table depth are dropped. A query transfer (func 1) answers with one result
// after one or two binary searches over the first entry_count entries, at
// most the table depth; the second search runs only when the entry found by
// the first lies within both bounds. Every search step reads the table and
// then uses the shared mass comparator on the entry read. The input
// stays stalled while a query is in progress, but a finished answer waits in
// the output register, so the next item can be taken before it is collected.
// entry_count must only be written while no query is in progress.
module sorted_mass_range_search #(
	parameter int TABLE_DEPTH = msrs_pkg::DEF_TABLE_DEPTH,
	parameter int MASS_BITS   = msrs_pkg::DEF_MASS_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [msrs_pkg::CNT_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       func,
	input  logic [msrs_pkg::IDX_W-1:0] entry_index,
	input  logic [MASS_BITS-1:0]       entry_mass,
	input  logic [MASS_BITS-1:0]       lower_bound,
	input  logic [MASS_BITS-1:0]       upper_bound,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       found,
	output logic [msrs_pkg::IDX_W-1:0] first_index,
	output logic [msrs_pkg::IDX_W-1:0] last_index
);

	logic [msrs_pkg::CNT_W-1:0] entry_count_q;
	logic                       out_valid_q;
	msrs_pkg::res_t             out_res_q;
	msrs_pkg::res_t             eng_res;
	logic                       eng_busy;
	logic                       eng_res_valid;
	logic                       res_ready;
	logic                       in_xfer;

	// Count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_wr_en) begin
			entry_count_q <= cfg_wr_data;
		end
	end

	// An input transfer starts the engine; it takes items only when idle.
	assign in_stall = eng_busy;
	assign in_xfer  = in_valid && !in_stall;

	msrs_engine #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.MASS_BITS   (MASS_BITS)
	) u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (in_xfer),
		.func        (func),
		.entry_index (entry_index),
		.entry_mass  (entry_mass),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound),
		.entry_count (entry_count_q),
		.res_ready   (res_ready),
		.busy        (eng_busy),
		.res_valid   (eng_res_valid),
		.res         (eng_res)
	);

	// Output register: takes a new answer when empty or being emptied.
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= eng_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && eng_res_valid) begin
			out_res_q <= eng_res;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = out_res_q.found;
	assign first_index = out_res_q.first;
	assign last_index  = out_res_q.last;

	// A query transfer always occupies the engine in the following cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (func == msrs_pkg::FUNC_QUERY) |=> in_stall)
		else $error("query transfer did not start the search");

	// A load transfer never blocks the input.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && (func == msrs_pkg::FUNC_LOAD) |=> !in_stall)
		else $error("load transfer left the input stalled");

	// A not-found answer carries zero indices.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (first_index == '0) && (last_index == '0))
		else $error("not-found answer with nonzero indices");

endmodule

### verif/mass_search_checker.sv
// ----------------------------------------------------------------------------
// mass_search_checker: result checker for the sorted mass range search
// Watches the configuration port and both channels, keeps its own copy of the
// mass table and the entry count, predicts the answer of every accepted query
// transfer and compares each result transfer with the oldest open prediction.
// ----------------------------------------------------------------------------
module mass_search_checker #(
	parameter int TABLE_DEPTH = msrs_pkg::DEF_TABLE_DEPTH,
	parameter int MASS_BITS   = msrs_pkg::DEF_MASS_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [msrs_pkg::CNT_W-1:0] cfg_wr_data,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic                       func,
	input  logic [msrs_pkg::IDX_W-1:0] entry_index,
	input  logic [MASS_BITS-1:0]       entry_mass,
	input  logic [MASS_BITS-1:0]       lower_bound,
	input  logic [MASS_BITS-1:0]       upper_bound,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic                       found,
	input  logic [msrs_pkg::IDX_W-1:0] first_index,
	input  logic [msrs_pkg::IDX_W-1:0] last_index,
	output int                         pending_results,
	output int                         mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [MASS_BITS-1:0]       mass_copy [TABLE_DEPTH];
	logic [msrs_pkg::CNT_W-1:0] count_copy = '0;
	msrs_pkg::res_t             expected_hits [$];

	// Answer of a range query over the used part of the table copy. The first
	// search finds the first entry at or above the lower bound, the second one
	// counts the leading entries at or below the upper bound.
	function automatic msrs_pkg::res_t predict_range(logic [MASS_BITS-1:0] lo_mass,
			logic [MASS_BITS-1:0] hi_mass);
		msrs_pkg::res_t hit;
		int unsigned    used;
		int unsigned    lo;
		int unsigned    hi;
		int unsigned    mid;
		int unsigned    first_pos;
		int unsigned    last_pos;
		hit = '0;
		used = (count_copy > TABLE_DEPTH) ? TABLE_DEPTH : count_copy;
		if (used == 0)
			return hit;
		lo = 0;
		hi = used;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (mass_copy[mid] < lo_mass)
				lo = mid + 1;
			else
				hi = mid;
		end
		first_pos = lo;
		if (first_pos >= used || mass_copy[first_pos] > hi_mass ||
				mass_copy[first_pos] < lo_mass)
			return hit;
		lo = 0;
		hi = used;
		while (lo < hi) begin
			mid = lo + (hi - lo) / 2;
			if (mass_copy[mid] <= hi_mass)
				lo = mid + 1;
			else
				hi = mid;
		end
		if (lo <= first_pos)
			return hit;
		last_pos = lo - 1;
		hit.found = 1'b1;
		hit.first = first_pos[msrs_pkg::IDX_W-1:0];
		hit.last  = last_pos[msrs_pkg::IDX_W-1:0];
		return hit;
	endfunction

	task automatic flag_field(string field, logic [63:0] want, logic [63:0] got);
		mismatch_count++;
		$error("%s mismatch: expected %0d, actual %0d", field, want, got);
	endtask

	// Track configuration, compare result transfers, predict query transfers.
	always @(posedge clk or negedge arst_n) begin
		msrs_pkg::res_t want;
		if (!arst_n) begin
			count_copy = '0;
			expected_hits.delete();
			pending_results = 0;
		end else begin
			if (cfg_wr_en)
				count_copy = cfg_wr_data;
			if (out_valid && !out_stall) begin
				if (expected_hits.size() == 0) begin
					mismatch_count++;
					$error("result transfer with no open query: found %0d, first %0d, last %0d",
						found, first_index, last_index);
				end else begin
					want = expected_hits.pop_front();
					if (found !== want.found)
						flag_field("found", 64'(want.found), 64'(found));
					if (first_index !== want.first)
						flag_field("first_index", 64'(want.first), 64'(first_index));
					if (last_index !== want.last)
						flag_field("last_index", 64'(want.last), 64'(last_index));
				end
			end
			if (in_valid && !in_stall) begin
				if (func == msrs_pkg::FUNC_QUERY)
					expected_hits.insert(expected_hits.size(),
						predict_range(lower_bound, upper_bound));
				else if (entry_index < TABLE_DEPTH)
					mass_copy[entry_index] = entry_mass;
			end
			pending_results = expected_hits.size();
		end
	end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the sorted mass range search
// Loads mass tables of many sizes and orders, sets the entry count between
// phases and sends range queries with bounds picked around the loaded masses,
// under changing idle patterns on both channels. The checker beside the block
// predicts and compares every answer.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = msrs_pkg::DEF_TABLE_DEPTH;
	localparam int MB           = msrs_pkg::DEF_MASS_BITS;
	localparam int IW           = msrs_pkg::IDX_W;
	localparam int CW           = msrs_pkg::CNT_W;
	localparam int RANDOM_ITEMS = 2000;
	localparam int DRAIN_CYCLES = 80;
	localparam int QUIET_LIMIT  = 4000;
	localparam logic [MB-1:0] MASS_MAX = '1;

	logic                       clk         = 1'b0;
	logic                       arst_n      = 1'b0;
	logic                       cfg_wr_en   = 1'b0;
	logic [msrs_pkg::CNT_W-1:0] cfg_wr_data = '0;
	logic                       in_valid    = 1'b0;
	logic                       in_stall;
	logic                       func        = msrs_pkg::FUNC_LOAD;
	logic [msrs_pkg::IDX_W-1:0] entry_index = '0;
	logic [MB-1:0]              entry_mass  = '0;
	logic [MB-1:0]              lower_bound = '0;
	logic [MB-1:0]              upper_bound = '0;
	logic                       out_valid;
	logic                       out_stall   = 1'b0;
	logic                       found;
	logic [msrs_pkg::IDX_W-1:0] first_index;
	logic [msrs_pkg::IDX_W-1:0] last_index;

	int          results_owed;
	int          mismatch_count;
	int          send_idle_pct = 38;
	int          recv_idle_pct = 58;
	int unsigned quiet_cycles  = 0;
	int unsigned filled        = 0;
	int unsigned used_entries  = 0;
	int unsigned random_items  = 0;
	logic [MB-1:0] shadow_mass [DEPTH];

	sorted_mass_range_search u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.func        (func),
		.entry_index (entry_index),
		.entry_mass  (entry_mass),
		.lower_bound (lower_bound),
		.upper_bound (upper_bound),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.found       (found),
		.first_index (first_index),
		.last_index  (last_index)
	);

	mass_search_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.entry_index     (entry_index),
		.entry_mass      (entry_mass),
		.lower_bound     (lower_bound),
		.upper_bound     (upper_bound),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.found           (found),
		.first_index     (first_index),
		.last_index      (last_index),
		.pending_results (results_owed),
		.mismatch_count  (mismatch_count)
	);

	always #1 clk = ~clk;

	// The receiver stalls at random, independent of the output valid.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// End the run when no transfer of either kind happens for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [MB-1:0] any_mass();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[MB-1:0];
	endfunction

	// Next mass of an ascending table, saturating at the largest mass.
	function automatic logic [MB-1:0] climb(logic [MB-1:0] m, int unsigned step_cap);
		logic [MB:0] sum;
		sum = m + $urandom_range(step_cap);
		return sum[MB] ? MASS_MAX : sum[MB-1:0];
	endfunction

	// Move a mass by one step down, not at all, or one step up.
	function automatic logic [MB-1:0] nudge(logic [MB-1:0] m);
		case ($urandom_range(2))
			0: return (m == '0) ? m : m - 1;
			1: return m;
			default: return (m == MASS_MAX) ? m : m + 1;
		endcase
	endfunction

	// Offer one input transfer after a random gap and hold it until taken.
	task automatic send_transfer(logic f, logic [msrs_pkg::IDX_W-1:0] idx, logic [MB-1:0] m,
			logic [MB-1:0] lo, logic [MB-1:0] hi);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		entry_index <= idx;
		entry_mass  <= m;
		lower_bound <= lo;
		upper_bound <= hi;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic send_load(logic [msrs_pkg::IDX_W-1:0] idx, logic [MB-1:0] m);
		shadow_mass[idx] = m;
		send_transfer(msrs_pkg::FUNC_LOAD, idx, m, any_mass(), any_mass());
	endtask

	task automatic send_query(logic [MB-1:0] lo, logic [MB-1:0] hi);
		send_transfer(msrs_pkg::FUNC_QUERY, IW'($urandom), any_mass(), lo, hi);
	endtask

	// Drop the input valid and wait until every open query has answered.
	task automatic wait_results_drained();
		in_valid <= 1'b0;
		do @(negedge clk); while (results_owed != 0);
	endtask

	// Change the entry count only once the block has gone quiet.
	task automatic write_entry_count(logic [msrs_pkg::CNT_W-1:0] value);
		wait_results_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		used_entries = (value > DEPTH) ? DEPTH : value;
	endtask

	// Load entries 0 to n-1, ascending with duplicates, or in random order.
	task automatic fill_table(int unsigned n, bit ascending);
		logic [MB-1:0] m;
		int unsigned   step_cap;
		case ($urandom_range(3))
			0: step_cap = 2;
			1: step_cap = 1000;
			2: step_cap = 1 << 24;
			default: step_cap = 32'h7fff_ffff;
		endcase
		if (n > 64)
			step_cap = 1 << 24;
		m = ($urandom_range(3) == 0) ? '0 : any_mass() >> $urandom_range(1, 39);
		for (int unsigned i = 0; i < n; i++) begin
			if (!ascending)
				m = any_mass();
			send_load(IW'(i), m);
			m = climb(m, step_cap);
		end
		if (n > filled)
			filled = n;
	endtask

	// Query with bounds mostly placed on or next to loaded masses.
	task automatic send_random_query();
		int unsigned   span;
		int unsigned   a;
		int unsigned   b;
		int unsigned   kind;
		logic [MB-1:0] lo;
		logic [MB-1:0] hi;
		logic [MB-1:0] t;
		span = (used_entries != 0) ? used_entries : filled;
		kind = (span == 0) ? 7 : $urandom_range(9);
		a = (span == 0) ? 0 : $urandom_range(span - 1);
		b = a + $urandom_range(8);
		if (span != 0 && b >= span)
			b = span - 1;
		case (kind)
			6: begin
				lo = nudge(shadow_mass[a]);
				hi = lo;
			end
			7: begin
				lo = any_mass();
				hi = any_mass();
			end
			8: begin
				// Crossed bounds: the lower bound is not below the upper one.
				lo = nudge(shadow_mass[b]);
				hi = nudge(shadow_mass[a]);
				if (lo < hi) begin
					t  = lo;
					lo = hi;
					hi = t;
				end
			end
			9: begin
				lo = $urandom_range(1) ? '0 : MASS_MAX;
				hi = MASS_MAX;
			end
			default: begin
				lo = nudge(shadow_mass[a]);
				hi = nudge(shadow_mass[b]);
			end
		endcase
		send_query(lo, hi);
	endtask

	initial begin
		int unsigned                n;
		int unsigned                nq;
		logic [msrs_pkg::CNT_W-1:0] count_value;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part. An empty table answers not found before anything is set.
		send_query('0, MASS_MAX);
		send_load(0, '0);
		send_load(1, 1);
		send_load(2, 5);
		send_load(3, 5);
		send_load(4, 100);
		send_load(5, {1'b1, {(MB-1){1'b0}}});
		send_load(6, MASS_MAX - 1);
		send_load(7, MASS_MAX);
		send_load(IW'(DEPTH - 1), MASS_MAX);
		filled = 8;
		write_entry_count(8);
		send_query('0, MASS_MAX);
		send_query(5, 5);
		send_query(2, 4);
		send_query(MASS_MAX, MASS_MAX);
		send_query('0, '0);
		send_query(100, 5);
		send_query(101, {1'b0, {(MB-1){1'b1}}});
		send_query(6, {1'b1, {(MB-1){1'b0}}});
		// A single used entry, then a table that is no longer sorted.
		write_entry_count(1);
		send_query('0, '0);
		send_query(1, MASS_MAX);
		write_entry_count(8);
		send_load(3, MASS_MAX);
		send_query(5, 5);
		send_query('0, MASS_MAX);
		// A count above the depth. With the widest bounds both searches only visit
		// position zero, the power-of-two positions and the depth less a power of two.
		for (int unsigned k = 1; k < DEPTH; k = k * 2) begin
			send_load(IW'(k), MB'(k));
			send_load(IW'(DEPTH - k), MASS_MAX - MB'(k));
		end
		write_entry_count('1);
		send_query('0, MASS_MAX);
		write_entry_count(CW'(DEPTH + 1));
		send_query('0, MASS_MAX);

		// Random phases: load a table, set the count, then query it.
		while (random_items < RANDOM_ITEMS) begin
			if (random_items < RANDOM_ITEMS / 3) begin
				send_idle_pct = 38;
				recv_idle_pct = 58;
			end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 58;
				recv_idle_pct = 38;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case ($urandom_range(19))
				0: n = 0;
				1: n = 1;
				2: n = 2;
				3: n = $urandom_range(65, 300);
				default: n = $urandom_range(3, 64);
			endcase
			fill_table(n, $urandom_range(9) != 0);
			random_items += n;
			count_value = CW'(n);
			if ($urandom_range(9) == 0)
				count_value = CW'($urandom_range(filled));
			write_entry_count(count_value);
			nq = $urandom_range(10, 40);
			for (int unsigned q = 0; q < nq; q++) begin
				// Now and then the sender holds off until all answers are back.
				if (q == 5 || $urandom_range(19) == 0)
					wait_results_drained();
				if (filled != 0 && $urandom_range(11) == 0)
					send_load(IW'($urandom_range(filled - 1)), any_mass());
				else
					send_random_query();
				random_items++;
			end
		end

		wait_results_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && results_owed == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
